### sv/assert_macros.svh
// assertion macros used by swel_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SWEL_ASSERT_IMP(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define SWEL_ASSERT_NXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define SWEL_ASSERT_IMP(lbl, clk, rst, pre, post)
`define SWEL_ASSERT_NXT(lbl, clk, rst, pre, post)

`endif

`endif

### sv/swel_pkg.sv
// types, constants and helpers of the sliding window event limiter
package swel_pkg;

  localparam int MAX_HISTORY = 64;
  localparam int HIST_W      = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
  localparam int CNT_W       = $clog2(MAX_HISTORY + 1);
  localparam int TIME_W      = 32;
  localparam int WINDOW_W    = 32;
  localparam int LIMIT_W     = 7;
  localparam int DROP_W      = 32;
  localparam int BK_W        = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(1);
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(65);
  localparam logic [DROP_W-1:0]   DROP_MAX     = '1;

  typedef enum logic [0:0] {
    CFG_WINDOW = 1'b0,
    CFG_LIMIT  = 1'b1
  } cfg_idx_t;

  typedef logic [HIST_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [TIME_W-1:0] time_t;

  typedef struct packed {
    logic  wr_en;
    slot_t wr_addr;
    time_t wr_data;
    logic  rd_en;
    slot_t rd_addr;
  } ring_req_t;

  function automatic slot_t slot_inc(slot_t s);
    if (s == slot_t'(MAX_HISTORY - 1)) begin
      return '0;
    end
    return s + slot_t'(1);
  endfunction

  // slot that lies back entries behind s on the ring, back in 0..MAX_HISTORY
  function automatic slot_t slot_back(slot_t s, count_t back);
    logic [CNT_W:0] s_ext;
    logic [CNT_W:0] b_ext;
    s_ext = (CNT_W + 1)'(s);
    b_ext = (CNT_W + 1)'(back);
    if (s_ext >= b_ext) begin
      return slot_t'(s_ext - b_ext);
    end
    return slot_t'(s_ext + (CNT_W + 1)'(MAX_HISTORY) - b_ext);
  endfunction

endpackage

### sv/swel_evt_if.sv
// event input channel
interface swel_evt_if;
  import swel_pkg::*;

  logic  valid;
  logic  ready;
  time_t event_time;
  logic  last;

  modport source (output valid, output event_time, output last, input ready);
  modport sink   (input valid, input event_time, input last, output ready);
endinterface

### sv/swel_res_if.sv
// result output channel
interface swel_res_if;
  import swel_pkg::*;

  logic              valid;
  logic              ready;
  logic              kept;
  logic [DROP_W-1:0] dropped_total;
  logic              order_error;
  logic              batch_done;

  modport source (output valid, output kept, output dropped_total,
                  output order_error, output batch_done, input ready);
  modport sink   (input valid, input kept, input dropped_total,
                  input order_error, input batch_done, output ready);
endinterface

### sv/swel_cfg_if.sv
// configuration write channel
interface swel_cfg_if;
  import swel_pkg::*;

  logic                valid;
  logic                ready;
  cfg_idx_t            index;
  logic [WINDOW_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/swel_ring.sv
// ring memory of kept event times with registered read
module swel_ring (
  input  logic                clk,
  input  swel_pkg::ring_req_t req,
  output swel_pkg::time_t     rd_data
);
  import swel_pkg::*;

  time_t mem [MAX_HISTORY];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end
endmodule

### sv/swel_ctrl.sv
// config registers, input stage, keep/drop decision, batch state and result register
`include "assert_macros.svh"

module swel_ctrl (
  input  logic                clk,
  input  logic                rst,
  swel_evt_if.sink            evt,
  swel_res_if.source          res,
  swel_cfg_if.sink            cfg,
  output swel_pkg::ring_req_t ring_req,
  input  swel_pkg::time_t     ring_rd
);
  import swel_pkg::*;

  logic [WINDOW_W-1:0] window_length;
  logic [LIMIT_W-1:0]  event_limit;

  logic  s1_valid;
  time_t s1_time;
  logic  s1_last;

  slot_t             write_slot;
  slot_t             write_slot_next;
  count_t            kept_count;
  time_t             previous_time;
  logic              have_previous;
  logic [DROP_W-1:0] drop_count;
  time_t             last_kept_time;

  logic              o_valid;
  logic              o_kept;
  logic [DROP_W-1:0] o_drop;
  logic              o_err;
  logic              o_done;

  logic              advance;
  logic              accept;
  logic              err;
  logic              drop_all;
  logic [BK_W-1:0]   back_raw;
  count_t            back;
  time_t             older;
  logic              keep_now;
  logic              drop_inc;
  logic [DROP_W-1:0] drop_upd;

  assign advance   = s1_valid && (!o_valid || res.ready);
  assign evt.ready = !s1_valid || advance;
  assign accept    = evt.valid && evt.ready;
  assign cfg.ready = 1'b1;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
      event_limit   <= LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_WINDOW: window_length <= cfg.data;
        CFG_LIMIT:  event_limit   <= cfg.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // decision
  always_comb begin
    err      = have_previous && (s1_time <= previous_time);
    drop_all = (event_limit <= LIMIT_W'(1));
    back_raw = BK_W'(event_limit) - BK_W'(1);
    back     = (back_raw > BK_W'(MAX_HISTORY)) ? count_t'(MAX_HISTORY) : count_t'(back_raw);
    older    = (back == count_t'(1)) ? last_kept_time : ring_rd;
    keep_now = !err && !drop_all &&
               ((kept_count < back) || ((s1_time - older) >= window_length));
    drop_inc = !err && !keep_now && (drop_count != DROP_MAX);
    drop_upd = drop_inc ? drop_count + DROP_W'(1) : drop_count;
  end

  always_comb begin
    write_slot_next = write_slot;
    if (advance) begin
      if (s1_last) begin
        write_slot_next = '0;
      end else if (keep_now) begin
        write_slot_next = slot_inc(write_slot);
      end
    end
  end

  // ring access: the next beat reads the entry back slots behind its write slot
  always_comb begin
    ring_req.wr_en   = advance && keep_now;
    ring_req.wr_addr = write_slot;
    ring_req.wr_data = s1_time;
    ring_req.rd_en   = accept;
    ring_req.rd_addr = slot_back(write_slot_next, back);
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_time <= evt.event_time;
      s1_last <= evt.last;
    end
  end

  // batch state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot    <= '0;
      kept_count    <= '0;
      previous_time <= '0;
      have_previous <= 1'b0;
      drop_count    <= '0;
    end else begin
      write_slot <= write_slot_next;
      if (advance) begin
        if (s1_last) begin
          kept_count    <= '0;
          previous_time <= '0;
          have_previous <= 1'b0;
          drop_count    <= '0;
        end else if (!err) begin
          previous_time <= s1_time;
          have_previous <= 1'b1;
          drop_count    <= drop_upd;
          if (keep_now && (kept_count != count_t'(MAX_HISTORY))) begin
            kept_count <= kept_count + count_t'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && keep_now) begin
      last_kept_time <= s1_time;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (res.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_kept <= keep_now;
      o_drop <= drop_upd;
      o_err  <= err;
      o_done <= s1_last;
    end
  end

  assign res.valid         = o_valid;
  assign res.kept          = o_kept;
  assign res.dropped_total = o_drop;
  assign res.order_error   = o_err;
  assign res.batch_done    = o_done;

  `SWEL_ASSERT_IMP(a_err_not_kept, clk, rst, o_valid && o_err, !o_kept)
  `SWEL_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, kept_count <= count_t'(MAX_HISTORY))
  `SWEL_ASSERT_NXT(a_last_clears, clk, rst, advance && s1_last,
    write_slot == '0 && kept_count == '0 && drop_count == '0 && !have_previous)
  `SWEL_ASSERT_NXT(a_keep_no_drop, clk, rst, advance && keep_now && !s1_last,
    $stable(drop_count) && last_kept_time == previous_time)
endmodule

### sv/sliding_window_event_limiter.sv
// top level: one event accepted per cycle unless the result side stalls
// throughput: one event per cycle unless stalled, set by the single ring read per event
// path: accept loads the input stage, which loads the result register once that is free
// a stalled result blocks intake once the input stage also holds a beat
// reset (synchronous, active high) clears the batch state and loads window 1, limit 65
module sliding_window_event_limiter (
  input logic         clk,
  input logic         rst,
  swel_evt_if.sink    evt,
  swel_res_if.source  res,
  swel_cfg_if.sink    cfg
);
  import swel_pkg::*;

  ring_req_t ring_req;
  time_t     ring_rd;

  swel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .evt      (evt),
    .res      (res),
    .cfg      (cfg),
    .ring_req (ring_req),
    .ring_rd  (ring_rd)
  );

  swel_ring u_ring (
    .clk     (clk),
    .req     (ring_req),
    .rd_data (ring_rd)
  );
endmodule

### tb/sliding_window_event_limiter_tb.sv
// testbench of the sliding window event limiter: directed and random beats checked against a local model
`timescale 1ns / 100ps

module sliding_window_event_limiter_tb;
  import swel_pkg::*;

  typedef struct {
    logic              kept;
    logic [DROP_W-1:0] dropped_total;
    logic              order_error;
    logic              batch_done;
  } verdict_t;

  class limiter_scoreboard;
    logic [WINDOW_W-1:0] window;
    logic [LIMIT_W-1:0]  limit;
    time_t               kept_ring [MAX_HISTORY];
    int unsigned         ring_head;
    int unsigned         ring_fill;
    time_t               last_time;
    bit                  seen_any;
    logic [DROP_W-1:0]   drops;
    verdict_t            pending_verdicts [$];
    int                  errors;

    function new();
      window = WINDOW_RESET;
      limit  = LIMIT_RESET;
      errors = 0;
      foreach (kept_ring[i]) kept_ring[i] = '0;
      start_batch();
    endfunction

    function void start_batch();
      ring_head = 0;
      ring_fill = 0;
      last_time = '0;
      seen_any  = 1'b0;
      drops     = '0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [WINDOW_W-1:0] data);
      if (idx == CFG_WINDOW) begin
        window = data;
      end else begin
        limit = data[LIMIT_W-1:0];
      end
    endfunction

    // drop all for limit at most one, else keep unless the (limit-1)-th most recent kept time is still in the window
    function bit admits(time_t t);
      int unsigned lim;
      int unsigned back;
      time_t       gap;
      lim = limit;
      if (lim <= 1) return 1'b0;
      if (lim > MAX_HISTORY + 1) lim = MAX_HISTORY + 1;
      back = lim - 1;
      if (ring_fill < back) return 1'b1;
      gap = t - kept_ring[(ring_head + MAX_HISTORY - back) % MAX_HISTORY];
      return gap >= window;
    endfunction

    function void note_event(time_t t, logic lst);
      verdict_t v;
      v.order_error = seen_any && (t <= last_time);
      v.kept = 1'b0;
      if (!v.order_error) begin
        v.kept = admits(t);
        if (v.kept) begin
          kept_ring[ring_head] = t;
          ring_head = (ring_head + 1) % MAX_HISTORY;
          if (ring_fill < MAX_HISTORY) ring_fill++;
        end else if (drops != DROP_MAX) begin
          drops++;
        end
        last_time = t;
        seen_any  = 1'b1;
      end
      v.dropped_total = drops;
      v.batch_done    = lst;
      pending_verdicts = {pending_verdicts, v};
      if (lst) start_batch();
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(logic k, logic [DROP_W-1:0] d, logic e, logic b);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        report("result beat with no event pending");
      end else begin
        v = pending_verdicts.pop_front();
        if (k !== v.kept)
          report($sformatf("kept %b, predicted %b", k, v.kept));
        if (d !== v.dropped_total)
          report($sformatf("dropped_total %0d, predicted %0d", d, v.dropped_total));
        if (e !== v.order_error)
          report($sformatf("order_error %b, predicted %b", e, v.order_error));
        if (b !== v.batch_done)
          report($sformatf("batch_done %b, predicted %b", b, v.batch_done));
      end
    endtask
  endclass

  logic clk;
  logic rst;

  swel_evt_if evt ();
  swel_res_if res ();
  swel_cfg_if cfg ();

  sliding_window_event_limiter dut (
    .clk (clk),
    .rst (rst),
    .evt (evt),
    .res (res),
    .cfg (cfg)
  );

  limiter_scoreboard sb = new();

  bit offering    = 1'b0;
  bit send_quiet  = 1'b0;
  bit take_quiet  = 1'b0;
  int hold_asks   = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int items_sent  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("[sliding_window_event_limiter] ERROR");
    $finish;
  end

  // result side: check accepted beats, idle at random, long hold-off on request
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      sb.check_result(res.kept, res.dropped_total, res.order_error, res.batch_done);
    if (hold_left == 0 && hold_served != hold_asks) begin
      hold_served++;
      hold_left = 400;
    end
    if (hold_left != 0) begin
      res.ready <= 1'b0;
      hold_left--;
    end else begin
      res.ready <= take_quiet || ($urandom_range(0, 99) >= 26);
    end
  end

  task automatic send_event(time_t t, logic lst, bit drain);
    evt.valid      <= 1'b1;
    evt.event_time <= t;
    evt.last       <= lst;
    offering = 1'b1;
    do @(posedge clk); while (!evt.ready);
    sb.note_event(t, lst);
    if (drain) begin
      evt.valid <= 1'b0;
      offering = 1'b0;
      while (sb.pending_verdicts.size() != 0) @(posedge clk);
    end else if (!send_quiet) begin
      while ($urandom_range(0, 99) < 26) begin
        evt.valid <= 1'b0;
        offering = 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    if (offering) begin
      evt.valid <= 1'b0;
      offering = 1'b0;
    end
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [WINDOW_W-1:0] w, logic [LIMIT_W-1:0] lim);
    logic [WINDOW_W-1:0] data;
    settle();
    cfg.valid <= 1'b1;
    cfg.index <= CFG_WINDOW;
    cfg.data  <= w;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(CFG_WINDOW, w);
    data = ($urandom() & 32'hFFFF_FF80) | WINDOW_W'(lim);
    cfg.index <= CFG_LIMIT;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(CFG_LIMIT, data);
    cfg.valid <= 1'b0;
  endtask

  // one batch of increasing times with a few out-of-order beats mixed in
  task automatic run_batch(int len, int unsigned step_max, bit drain_mid);
    time_t       cur;
    time_t       t;
    longint      span;
    int unsigned back_off;
    if (step_max > 32'hFFFF_FFFF / len) step_max = 32'hFFFF_FFFF / len;
    if (step_max == 0) step_max = 1;
    span = longint'(len) * longint'(step_max);
    case ($urandom_range(0, 3))
      0: cur = '0;
      1: cur = time_t'(64'hFFFF_FFFF - span);
      default: cur = time_t'($urandom_range(0, 32'(64'hFFFF_FFFF - span)));
    endcase
    for (int i = 0; i < len; i++) begin
      if (i != 0 && $urandom_range(0, 99) < 6) begin
        back_off = $urandom_range(0, 100);
        t = (cur < back_off) ? time_t'(0) : cur - back_off;
      end else begin
        if (i != 0) cur = cur + $urandom_range(1, step_max);
        t = cur;
      end
      send_event(t, i == len - 1, drain_mid && i == len / 2);
      items_sent++;
    end
  endtask

  initial begin
    int                  p;
    int                  len;
    int unsigned         eff;
    longint              step64;
    logic [WINDOW_W-1:0] w;
    logic [LIMIT_W-1:0]  lim;

    rst            <= 1'b1;
    evt.valid      <= 1'b0;
    evt.event_time <= '0;
    evt.last       <= 1'b0;
    cfg.valid      <= 1'b0;
    cfg.index      <= CFG_WINDOW;
    cfg.data       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: equal and older times, top of the time range
    send_event(32'h0000_0000, 1'b0, 1'b0);
    send_event(32'h0000_0000, 1'b0, 1'b0);
    send_event(32'h0000_0007, 1'b0, 1'b0);
    send_event(32'h0000_0003, 1'b0, 1'b0);
    send_event(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_event(32'h0000_0064, 1'b1, 1'b0);
    // limit one drops everything, out-of-order beat ends the batch
    configure(32'hFFFF_FFFF, 7'd1);
    send_event(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_event(32'h0000_0005, 1'b1, 1'b0);
    // limit zero acts as one
    configure(32'd5, 7'd0);
    send_event(32'h0000_0001, 1'b0, 1'b0);
    send_event(32'h0000_0002, 1'b1, 1'b0);
    // empty window keeps everything, oversized limit clamps
    configure(32'd0, 7'd127);
    send_event(32'h0000_000A, 1'b0, 1'b0);
    send_event(32'h0000_000B, 1'b0, 1'b0);
    send_event(32'h0000_000C, 1'b0, 1'b0);
    send_event(32'h0000_000D, 1'b1, 1'b0);
    // widest window with limit two
    configure(32'hFFFF_FFFF, 7'd2);
    send_event(32'h0000_0000, 1'b0, 1'b0);
    send_event(32'h0000_0001, 1'b0, 1'b0);
    send_event(32'hFFFF_FFFE, 1'b0, 1'b0);
    send_event(32'hFFFF_FFFF, 1'b1, 1'b0);
    // window edge: exactly window_length apart is outside
    configure(32'd10, 7'd3);
    send_event(32'd100, 1'b0, 1'b0);
    send_event(32'd105, 1'b0, 1'b0);
    send_event(32'd109, 1'b0, 1'b0);
    send_event(32'd110, 1'b0, 1'b0);
    send_event(32'd110, 1'b0, 1'b0);
    send_event(32'd115, 1'b1, 1'b0);

    p = 0;
    while (items_sent < 1500) begin
      w   = WINDOW_W'($urandom_range(1, 2000));
      lim = LIMIT_W'($urandom_range(2, 65));
      case (p % 8)
        0: begin
          w   = 32'd1;
          lim = 7'd65;
        end
        2: w = 32'hFFFF_FFFF;
        3: begin
          w   = WINDOW_W'($urandom_range(1, 500));
          lim = 7'd2;
        end
        4: w = '0;
        5: lim = 7'd65;
        6: begin
          case ($urandom_range(0, 3))
            0: lim = 7'd0;
            1: lim = 7'd1;
            2: lim = 7'd127;
            default: lim = LIMIT_W'($urandom_range(66, 127));
          endcase
        end
        7: w = $urandom();
        default: ;
      endcase
      configure(w, lim);
      eff = (lim <= 1) ? 2 : ((lim > MAX_HISTORY + 1) ? MAX_HISTORY + 1 : lim);
      step64 = (w == 0) ? 1000 : (2 * longint'(w)) / (eff - 1) + 1;
      if (step64 > 64'hFFFF_FFFF) step64 = 64'hFFFF_FFFF;
      send_quiet = (p == 5);
      take_quiet = (p == 5);
      if (p == 2) hold_asks++;
      for (int b = 0; b < 3; b++) begin
        if (p == 2 && b == 0)
          len = 200;
        else if ($urandom_range(0, 9) == 0)
          len = $urandom_range(100, 200);
        else
          len = $urandom_range(1, 40);
        run_batch(len, int'(step64), p == 3 && b == 1);
      end
      p++;
    end
    send_quiet = 1'b0;
    take_quiet = 1'b0;

    if (offering) begin
      evt.valid <= 1'b0;
      offering = 1'b0;
    end
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending_verdicts.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_verdicts.size()));
    if (sb.errors == 0) begin
      $display("[sliding_window_event_limiter] OK");
    end else begin
      $display("[sliding_window_event_limiter] ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/swel_pkg.sv
sv/swel_evt_if.sv
sv/swel_res_if.sv
sv/swel_cfg_if.sv
sv/swel_ring.sv
sv/swel_ctrl.sv
sv/sliding_window_event_limiter.sv
tb/sliding_window_event_limiter_tb.sv
